// File: src/llrb_pkg.sv
package llrb_pkg;

    // Ring store geometry. The ring index wraps by dropping carry bits, so the
    // capacity is a power of two.
    localparam int CAPACITY = 4096;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int BYTE_W   = 8;

    localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(CAPACITY);
    localparam logic [ADDR_W-1:0] HALF_COUNT = ADDR_W'(CAPACITY / 2);

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

    typedef enum logic [1:0] {
        MODE_TEXT   = 2'd0,
        MODE_EOL    = 2'd1,
        MODE_READ   = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_STORE,
        ST_RDATA,
        ST_RESULT
    } state_t;

endpackage

// File: src/llrb_ram.sv
module llrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/line_log_ring_buffer.sv
// A read of a held byte passes through ST_RDATA and then ST_RESULT, any other word only through
// ST_RESULT, which waits until the output register is free. A store into a full ring first scans
// for the oldest newline, one byte a cycle through the store's read port, then writes in ST_STORE.
// A new word is taken only in the idle state, after the last word's result has been registered.
// Reset (aresetn low at a clock edge) empties the ring and clears the line length;
// the byte store itself is not cleared, only held bytes are ever read.
module line_log_ring_buffer (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] data_byte, [19:8] read_offset, [23:20] zero
    input  logic [1:0]  s_tuser,   // [1:0] mode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] read_byte, [20:8] fill_level, [23:21] zero
    output logic [0:0]  m_tuser    // [0] byte_valid
);

    localparam int ADDR_W = llrb_pkg::ADDR_W;
    localparam int CNT_W  = llrb_pkg::CNT_W;
    localparam int BYTE_W = llrb_pkg::BYTE_W;

    // Control state. oldest_reg is the ring index of the oldest byte, held_reg the
    // number of bytes in the ring and cur_len_reg the stored length of the open line.
    llrb_pkg::state_t    state_reg, state_next;
    logic [ADDR_W-1:0]   oldest_reg, oldest_next;
    logic [CNT_W-1:0]    held_reg, held_next;
    logic [ADDR_W-1:0]   cur_len_reg, cur_len_next;

    // The word being worked on.
    llrb_pkg::mode_t     mode_reg, mode_next;
    logic [BYTE_W-1:0]   data_reg, data_next;
    logic [BYTE_W-1:0]   res_byte_reg, res_byte_next;
    logic                res_valid_reg, res_valid_next;

    // Eviction scan: scan_idx_reg is the next offset to read, chk_idx_reg the offset
    // whose byte the store returns in this cycle when chk_valid_reg is set.
    logic [CNT_W-1:0]    scan_idx_reg, scan_idx_next;
    logic [ADDR_W-1:0]   chk_idx_reg, chk_idx_next;
    logic                chk_valid_reg, chk_valid_next;

    // Output register.
    logic                m_tvalid_reg, m_tvalid_next;
    logic [BYTE_W-1:0]   m_byte_reg, m_byte_next;
    logic                m_bvalid_reg, m_bvalid_next;
    logic [CNT_W-1:0]    m_fill_reg, m_fill_next;

    // Store port.
    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [BYTE_W-1:0]   ram_wdata, ram_rdata;

    // Input word fields.
    llrb_pkg::mode_t     in_mode;
    logic [BYTE_W-1:0]   in_data;
    logic [ADDR_W-1:0]   in_offset;

    logic                accept;
    logic                in_store;
    logic                out_free;
    logic                nl_found;
    logic                scan_end;
    logic [CNT_W-1:0]    evict_len;
    logic [CNT_W-1:0]    held_after_evict;

    assign in_mode   = llrb_pkg::mode_t'(s_tuser);
    assign in_data   = s_tdata[7:0];
    assign in_offset = s_tdata[19:8];

    assign s_tready = (state_reg == llrb_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // A text byte goes into the ring only while the open line is below half capacity.
    assign in_store = ((in_mode == llrb_pkg::MODE_TEXT) &&
                       (cur_len_reg < llrb_pkg::HALF_COUNT)) ||
                      (in_mode == llrb_pkg::MODE_EOL);

    // Scan bookkeeping. The ring is full during a scan, so the last offset is all ones.
    assign nl_found         = chk_valid_reg && (ram_rdata == llrb_pkg::NEWLINE_BYTE);
    assign scan_end         = chk_valid_reg && (chk_idx_reg == {ADDR_W{1'b1}});
    assign evict_len        = {1'b0, chk_idx_reg} + CNT_W'(1);
    assign held_after_evict = held_reg - evict_len;

    llrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (llrb_pkg::CAPACITY)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            llrb_pkg::ST_IDLE: begin
                if (accept) begin
                    if (in_mode == llrb_pkg::MODE_READ &&
                        {1'b0, in_offset} < held_reg) begin
                        state_next = llrb_pkg::ST_RDATA;
                    end else if (in_store && held_reg == llrb_pkg::FULL_COUNT) begin
                        state_next = llrb_pkg::ST_SCAN;
                    end else begin
                        state_next = llrb_pkg::ST_RESULT;
                    end
                end
            end
            llrb_pkg::ST_SCAN: begin
                if (nl_found || scan_end) begin
                    state_next = llrb_pkg::ST_STORE;
                end
            end
            llrb_pkg::ST_STORE: begin
                state_next = llrb_pkg::ST_RESULT;
            end
            llrb_pkg::ST_RDATA: begin
                state_next = llrb_pkg::ST_RESULT;
            end
            llrb_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = llrb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = llrb_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and store port control.
    always_comb begin
        oldest_next    = oldest_reg;
        held_next      = held_reg;
        cur_len_next   = cur_len_reg;
        mode_next      = mode_reg;
        data_next      = data_reg;
        res_byte_next  = res_byte_reg;
        res_valid_next = res_valid_reg;
        scan_idx_next  = scan_idx_reg;
        chk_idx_next   = chk_idx_reg;
        chk_valid_next = 1'b0;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_byte_next    = m_byte_reg;
        m_bvalid_next  = m_bvalid_reg;
        m_fill_next    = m_fill_reg;
        ram_we         = 1'b0;
        ram_waddr      = oldest_reg + held_reg[ADDR_W-1:0];
        ram_wdata      = (mode_reg == llrb_pkg::MODE_TEXT) ? data_reg
                                                            : llrb_pkg::NEWLINE_BYTE;
        ram_re         = 1'b0;
        ram_raddr      = oldest_reg + scan_idx_reg[ADDR_W-1:0];

        unique case (state_reg)
            llrb_pkg::ST_IDLE: begin
                if (accept) begin
                    mode_next      = in_mode;
                    data_next      = in_data;
                    res_byte_next  = '0;
                    res_valid_next = 1'b0;
                    scan_idx_next  = '0;
                    if (in_mode == llrb_pkg::MODE_READ) begin
                        // A read beyond the fill level answers zero, not valid.
                        ram_raddr = oldest_reg + in_offset;
                        ram_re    = ({1'b0, in_offset} < held_reg);
                    end else if (in_store && held_reg != llrb_pkg::FULL_COUNT) begin
                        // Room left: write the byte at once.
                        ram_we    = 1'b1;
                        ram_wdata = (in_mode == llrb_pkg::MODE_TEXT) ? in_data
                                                                      : llrb_pkg::NEWLINE_BYTE;
                        held_next = held_reg + CNT_W'(1);
                        cur_len_next = (in_mode == llrb_pkg::MODE_TEXT) ?
                                       cur_len_reg + ADDR_W'(1) : '0;
                    end
                end
            end
            llrb_pkg::ST_SCAN: begin
                if (nl_found) begin
                    // Drop the oldest line including its newline.
                    oldest_next = oldest_reg + chk_idx_reg + ADDR_W'(1);
                    held_next   = held_after_evict;
                    if ({1'b0, cur_len_reg} > held_after_evict) begin
                        cur_len_next = held_after_evict[ADDR_W-1:0];
                    end
                end else if (scan_end) begin
                    // No newline anywhere: the whole ring goes.
                    held_next    = '0;
                    cur_len_next = '0;
                end else begin
                    // Reads run one ahead of the compare; surplus reads are ignored.
                    ram_re         = !scan_idx_reg[CNT_W-1];
                    chk_valid_next = ram_re;
                    chk_idx_next   = scan_idx_reg[ADDR_W-1:0];
                    scan_idx_next  = scan_idx_reg + CNT_W'(1);
                end
            end
            llrb_pkg::ST_STORE: begin
                ram_we       = 1'b1;
                held_next    = held_reg + CNT_W'(1);
                cur_len_next = (mode_reg == llrb_pkg::MODE_TEXT) ?
                               cur_len_reg + ADDR_W'(1) : '0;
            end
            llrb_pkg::ST_RDATA: begin
                res_byte_next  = ram_rdata;
                res_valid_next = 1'b1;
            end
            llrb_pkg::ST_RESULT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_byte_next   = res_byte_reg;
                    m_bvalid_next = res_valid_reg;
                    m_fill_next   = held_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= llrb_pkg::ST_IDLE;
            oldest_reg    <= '0;
            held_reg      <= '0;
            cur_len_reg   <= '0;
            chk_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            held_reg      <= held_next;
            cur_len_reg   <= cur_len_next;
            chk_valid_reg <= chk_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg      <= mode_next;
        data_reg      <= data_next;
        res_byte_reg  <= res_byte_next;
        res_valid_reg <= res_valid_next;
        scan_idx_reg  <= scan_idx_next;
        chk_idx_reg   <= chk_idx_next;
        m_byte_reg    <= m_byte_next;
        m_bvalid_reg  <= m_bvalid_next;
        m_fill_reg    <= m_fill_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(24 - BYTE_W - CNT_W){1'b0}}, m_fill_reg, m_byte_reg};
    assign m_tuser  = m_bvalid_reg;

    // An eviction scan only runs on a full ring.
    a_scan_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == llrb_pkg::ST_SCAN) |-> (held_reg == llrb_pkg::FULL_COUNT))
        else $error("eviction scan on a ring that is not full");

    // The fill level never passes capacity, and the open line fits in what is held.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (held_reg <= llrb_pkg::FULL_COUNT) && ({1'b0, cur_len_reg} <= held_reg))
        else $error("fill level or line length out of range");

    // A new result word only follows the result state.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !$past(m_tvalid_reg && !m_tready)) |->
        $past(state_reg == llrb_pkg::ST_RESULT))
        else $error("result word without a finished item");

    // Each taken word leaves the idle state on the next edge.
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != llrb_pkg::ST_IDLE))
        else $error("block stayed idle after taking a word");

endmodule

// File: tb/tb_line_log_ring_buffer.sv
module tb_line_log_ring_buffer;

    // The receiver is held off for this many cycles once, while the sender keeps
    // offering words, so that the block backs up and drops s_tready.
    localparam int HOLD_CYCLES  = 400;
    // Longest stretch with no word moving on either side. An eviction scan may
    // walk most of the ring, and the long hold-off adds to that.
    localparam int QUIET_LIMIT  = 20000;
    // Cycles allowed after the last result before the verdict.
    localparam int DRAIN_CYCLES = 16;
    localparam int DIR_ROWS     = 21;
    // Number of input words the run aims for.
    localparam int WORD_TARGET  = 1150;

    // One result word as the block reports it.
    typedef struct packed {
        logic [7:0]  rbyte;
        logic        valid;
        logic [12:0] fill;
    } echo_t;

    // One row of the directed table. Where typed is set, want holds the result
    // written out by hand; otherwise the predictor supplies it.
    typedef struct packed {
        llrb_pkg::mode_t mode;
        logic [7:0]      data;
        logic [11:0]     offset;
        bit              typed;
        echo_t           want;
    } dir_row_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // [7:0] data_byte, [19:8] read_offset, [23:20] zero
    logic [1:0]  s_tuser  = '0;   // [1:0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // [7:0] read_byte, [20:8] fill_level, [23:21] zero
    logic [0:0]  m_tuser;         // [0] byte_valid

    line_log_ring_buffer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Our own picture of the ring. Entries that were never written stay
    // unknown, which is harmless because only held bytes are ever read.
    logic [7:0]                  ring_copy [llrb_pkg::CAPACITY];
    logic [llrb_pkg::ADDR_W-1:0] ring_head     = '0;
    int unsigned                 ring_count    = 0;
    int unsigned                 open_line_len = 0;

    echo_t expected_words [$];

    int  mismatches  = 0;
    int  words_sent  = 0;
    int  quiet_count = 0;
    bit  tx_steady   = 1'b0;
    bit  rx_steady   = 1'b0;
    bit  sink_hold_req = 1'b0;

    // Directed rows. Starting from an empty ring after reset, the first rows
    // cover reads of an empty ring, the unused mode, bytes at both extremes, a
    // newline sent as text, reads at and past the fill level and at the top
    // offset. The remaining rows are left to the predictor.
    dir_row_t directed_rows [DIR_ROWS] = '{
        '{llrb_pkg::MODE_READ,   8'h00, 12'h000, 1'b1, '{8'h00, 1'b0, 13'd0}},
        '{llrb_pkg::MODE_UNUSED, 8'hFF, 12'hFFF, 1'b1, '{8'h00, 1'b0, 13'd0}},
        '{llrb_pkg::MODE_TEXT,   8'h41, 12'h000, 1'b1, '{8'h00, 1'b0, 13'd1}},
        '{llrb_pkg::MODE_TEXT,   8'hFF, 12'hFFF, 1'b1, '{8'h00, 1'b0, 13'd2}},
        '{llrb_pkg::MODE_TEXT,   8'h00, 12'h000, 1'b1, '{8'h00, 1'b0, 13'd3}},
        '{llrb_pkg::MODE_TEXT,   8'h0A, 12'h000, 1'b1, '{8'h00, 1'b0, 13'd4}},
        '{llrb_pkg::MODE_EOL,    8'hFF, 12'hFFF, 1'b1, '{8'h00, 1'b0, 13'd5}},
        '{llrb_pkg::MODE_READ,   8'h00, 12'h000, 1'b1, '{8'h41, 1'b1, 13'd5}},
        '{llrb_pkg::MODE_READ,   8'hFF, 12'h001, 1'b1, '{8'hFF, 1'b1, 13'd5}},
        '{llrb_pkg::MODE_READ,   8'h00, 12'h003, 1'b1, '{8'h0A, 1'b1, 13'd5}},
        '{llrb_pkg::MODE_READ,   8'h00, 12'h004, 1'b1, '{8'h0A, 1'b1, 13'd5}},
        '{llrb_pkg::MODE_READ,   8'h00, 12'h005, 1'b1, '{8'h00, 1'b0, 13'd5}},
        '{llrb_pkg::MODE_READ,   8'h00, 12'hFFF, 1'b1, '{8'h00, 1'b0, 13'd5}},
        '{llrb_pkg::MODE_UNUSED, 8'h0A, 12'h000, 1'b1, '{8'h00, 1'b0, 13'd5}},
        '{llrb_pkg::MODE_TEXT,   8'h80, 12'hAAA, 1'b0, '0},
        '{llrb_pkg::MODE_TEXT,   8'h7F, 12'h555, 1'b0, '0},
        '{llrb_pkg::MODE_EOL,    8'h00, 12'h000, 1'b0, '0},
        '{llrb_pkg::MODE_READ,   8'hAA, 12'h006, 1'b0, '0},
        '{llrb_pkg::MODE_TEXT,   8'h55, 12'hFFF, 1'b0, '0},
        '{llrb_pkg::MODE_READ,   8'h00, 12'h800, 1'b0, '0},
        '{llrb_pkg::MODE_READ,   8'h00, 12'h555, 1'b0, '0}
    };

    // Drop the oldest line, newline included. When no newline is held at all,
    // the whole ring is emptied. The open line can never be longer than what
    // is left.
    function automatic void drop_oldest_line();
        int unsigned i;
        for (i = 0; i < ring_count; i++) begin
            if (ring_copy[ring_head + llrb_pkg::ADDR_W'(i)] == llrb_pkg::NEWLINE_BYTE) begin
                ring_head  = ring_head + llrb_pkg::ADDR_W'(i + 1);
                ring_count = ring_count - (i + 1);
                if (open_line_len > ring_count) begin
                    open_line_len = ring_count;
                end
                return;
            end
        end
        ring_count    = 0;
        open_line_len = 0;
    endfunction

    function automatic void put_byte(input logic [7:0] value);
        if (ring_count >= llrb_pkg::CAPACITY) begin
            drop_oldest_line();
        end
        ring_copy[ring_head + llrb_pkg::ADDR_W'(ring_count)] = value;
        ring_count++;
    endfunction

    // Apply one input word to our copy of the ring and return the result the
    // block should give for it.
    function automatic echo_t predict_word(input llrb_pkg::mode_t mode,
                                           input logic [7:0] data,
                                           input logic [11:0] offset);
        echo_t res;
        res = '0;
        case (mode)
            llrb_pkg::MODE_TEXT: begin
                // Bytes past half the capacity in one line are dropped.
                if (open_line_len < llrb_pkg::CAPACITY / 2) begin
                    put_byte(data);
                    open_line_len++;
                end
            end
            llrb_pkg::MODE_EOL: begin
                put_byte(llrb_pkg::NEWLINE_BYTE);
                open_line_len = 0;
            end
            llrb_pkg::MODE_READ: begin
                if (offset < ring_count) begin
                    res.rbyte = ring_copy[ring_head + llrb_pkg::ADDR_W'(offset)];
                    res.valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
        res.fill = 13'(ring_count);
        return res;
    endfunction

    // Offer one word and wait until it is taken. The prediction is made at the
    // accepting edge, so the ring copy is always in step with the block. The
    // valid line is lowered only when an idle gap follows, which keeps it to a
    // single assignment per time step.
    task automatic send_word(input llrb_pkg::mode_t mode, input logic [7:0] data,
                             input logic [11:0] offset, input bit typed,
                             input echo_t want);
        echo_t guess;
        tx_steady = (words_sent >= 150 && words_sent < 320);
        rx_steady = tx_steady;
        if (!tx_steady && $urandom_range(99) < 33) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 33);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, offset, data};
        s_tuser  <= mode;
        do @(posedge aclk); while (!s_tready);
        guess = predict_word(mode, data, offset);
        expected_words.push_back(typed ? want : guess);
        words_sent++;
    endtask

    // One log line of random content, with reads and unused-mode words mixed
    // in. Now and then the newline is left out, so the next line runs on.
    task automatic send_line(input int unsigned text_len, input int unsigned read_pct);
        int unsigned k;
        logic [7:0]  b;
        logic [11:0] off;
        for (k = 0; k < text_len; k++) begin
            if ($urandom_range(99) < read_pct) begin
                case ($urandom_range(3))
                    0: off = 12'($urandom);
                    1: off = (ring_count < llrb_pkg::CAPACITY) ? 12'(ring_count)
                                                                : 12'($urandom);
                    default: off = (ring_count > 0) ? 12'($urandom_range(ring_count - 1))
                                                    : 12'd0;
                endcase
                send_word(llrb_pkg::MODE_READ, 8'($urandom), off, 1'b0, '0);
            end
            if ($urandom_range(99) < 3) begin
                send_word(llrb_pkg::MODE_UNUSED, 8'($urandom), 12'($urandom), 1'b0, '0);
            end
            b = ($urandom_range(99) < 6) ? llrb_pkg::NEWLINE_BYTE : 8'($urandom);
            send_word(llrb_pkg::MODE_TEXT, b, 12'($urandom), 1'b0, '0);
        end
        if ($urandom_range(99) < 92) begin
            send_word(llrb_pkg::MODE_EOL, 8'($urandom), 12'($urandom), 1'b0, '0);
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Receiver side. It stalls at random, except in the steady stretch, and
    // once holds off for a long count of its own when asked to.
    initial begin
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                m_tready <= rx_steady || ($urandom_range(99) >= 33);
            end
        end
    end

    // Each accepted result word is checked against the oldest expectation.
    always @(posedge aclk) begin
        echo_t got;
        echo_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.rbyte = m_tdata[7:0];
            got.fill  = m_tdata[20:8];
            got.valid = m_tuser[0];
            if (expected_words.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected result word: byte %h valid %b fill %0d",
                             got.rbyte, got.valid, got.fill);
                end
                mismatches++;
            end else begin
                want = expected_words.pop_front();
                if (got.rbyte !== want.rbyte || got.valid !== want.valid ||
                    got.fill !== want.fill) begin
                    if (mismatches < 10) begin
                        $display("result mismatch: byte %h/%h valid %b/%b fill %0d/%0d",
                                 want.rbyte, got.rbyte, want.valid, got.valid,
                                 want.fill, got.fill);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which no word moves on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_count <= 0;
        end else if (quiet_count >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    initial begin
        int i;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < DIR_ROWS; i++) begin
            send_word(directed_rows[i].mode, directed_rows[i].data, directed_rows[i].offset,
                      directed_rows[i].typed, directed_rows[i].want);
        end

        // Random lines of mixed length.
        while (words_sent < 450) begin
            send_line(($urandom_range(99) < 85) ? $urandom_range(0, 40)
                                                : $urandom_range(60, 300), 30);
        end

        // The receiver is held off at the start of this stretch to back the
        // block up while the sender keeps offering words.
        sink_hold_req = 1'b1;
        while (words_sent < WORD_TARGET) begin
            send_line(($urandom_range(99) < 85) ? $urandom_range(0, 30)
                                                : $urandom_range(40, 120), 25);
        end
        s_tvalid <= 1'b0;

        while (expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
